// ===== rtl/core/rccp_pkg.sv =====
// Shared types, constants and helpers of the control packet parser.
package rccp_pkg;

  localparam int PACKET_BYTES = 14;

  localparam logic [3:0] LAST_POS   = 4'(PACKET_BYTES - 1);
  localparam logic [3:0] CHECK_POS  = 4'd12;
  localparam logic [3:0] STICK_LAST = 4'd10;
  localparam logic [3:0] ADDR_LAST  = 4'd2;
  localparam logic [3:0] FLAG_POS   = 4'd11;
  localparam logic [3:0] COUNT_MAX  = 4'hF;
  localparam logic [3:0] STICK_BASE = 4'd3;

  localparam logic [7:0] BEACON_FIRST  = 8'hBE;
  localparam logic [7:0] BEACON_SECOND = 8'hAC;

  localparam logic [15:0] LINK_TIMEOUT_RST = 16'd40;
  localparam logic [15:0] SILENCE_MAX      = 16'hFFFF;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDR     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINK_TIMEOUT = 1'b1;

  localparam int FLAG_ARM   = 0;
  localparam int FLAG_FLIP  = 1;
  localparam int FLAG_RATE  = 2;
  localparam int FLAG_ALT   = 3;

  typedef enum logic [2:0] {
    STATUS_OK       = 3'd0,
    STATUS_LEN_ERR  = 3'd1,
    STATUS_ADDR_ERR = 3'd2,
    STATUS_SUM_ERR  = 3'd3,
    STATUS_LINK     = 3'd4
  } status_t;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef struct packed {
    op_t        operation;
    logic [7:0] data_byte;
    logic       last_byte;
  } beat_t;

  typedef struct packed {
    status_t            status;
    logic [23:0]        sender_target;
    logic signed [11:0] throttle;
    logic signed [11:0] roll;
    logic signed [11:0] pitch;
    logic signed [11:0] yaw;
    logic               arm;
    logic               flip;
    logic               rate_mode;
    logic               auto_altitude;
    logic [7:0]         attitude_reset;
    logic               link_up;
  } result_t;

  // Handshake between the input register and the packet logic.
  typedef struct packed {
    logic  valid;
    beat_t beat;
  } stage_t;

  // Saturate at 4095, then subtract the 2048 center, which only flips bit 11.
  function automatic logic signed [11:0] stick_scale(input logic [15:0] raw);
    logic [11:0] sat;
    sat = (|raw[15:12]) ? 12'hFFF : raw[11:0];
    return {~sat[11], sat[10:0]};
  endfunction

endpackage

// ===== rtl/core/rccp_in_if.sv =====
// Input channel of the control packet parser.
interface rccp_in_if import rccp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, operation, data_byte, last_byte, input ready);
  modport sink (input valid, operation, data_byte, last_byte, output ready);
endinterface

// ===== rtl/core/rccp_out_if.sv =====
// Result channel of the control packet parser.
interface rccp_out_if import rccp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [23:0]        sender_target;
  logic signed [11:0] throttle;
  logic signed [11:0] roll;
  logic signed [11:0] pitch;
  logic signed [11:0] yaw;
  logic               arm;
  logic               flip;
  logic               rate_mode;
  logic               auto_altitude;
  logic [7:0]         attitude_reset;
  logic               link_up;

  modport source (output valid, status, sender_target, throttle, roll, pitch, yaw,
                  arm, flip, rate_mode, auto_altitude, attitude_reset, link_up,
                  input ready);
  modport sink (input valid, status, sender_target, throttle, roll, pitch, yaw,
                arm, flip, rate_mode, auto_altitude, attitude_reset, link_up,
                output ready);
endinterface

// ===== rtl/core/rccp_cfg_if.sv =====
// Configuration write channel of the control packet parser.
interface rccp_cfg_if import rccp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/rccp_in_stage.sv =====
// Input register: holds one beat until the packet logic takes it.
module rccp_in_stage import rccp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  rccp_in_if.sink   in_ch,
  input  logic      advance,
  output stage_t    stage
);

  logic  valid_r, valid_nxt;
  beat_t beat_r, beat_nxt;
  logic  load;

  assign in_ch.ready = !valid_r || advance;
  assign load        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    beat_nxt  = beat_r;
    if (load) begin
      valid_nxt = 1'b1;
      beat_nxt  = '{operation: op_t'(in_ch.operation), data_byte: in_ch.data_byte,
                    last_byte: in_ch.last_byte};
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    beat_r <= beat_nxt;
  end

  assign stage = '{valid: valid_r, beat: beat_r};

  a_adv_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    advance |-> valid_r) else $error("input stage advanced while empty");

  a_hold_unless_adv: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !advance |=> valid_r && $stable(beat_r))
    else $error("input stage lost a beat");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> valid_r) else $error("loaded beat not marked valid");

endmodule

// ===== rtl/core/rccp_parse.sv =====
// Packet assembly, checks, silence counter and configuration registers.
module rccp_parse import rccp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  rccp_cfg_if.sink  cfg_ch,
  input  stage_t    stage,
  input  logic      advance,
  output logic      res_valid,
  output result_t   res
);

  logic [23:0] own_addr_r, own_addr_nxt;
  logic [15:0] timeout_r, timeout_nxt;

  logic [3:0]  cnt_r, cnt_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [23:0] target_r, target_nxt;
  logic [15:0] stick_r [4];
  logic [15:0] stick_nxt [4];
  logic [7:0]  flag_r, flag_nxt;
  logic [7:0]  rst_byte_r, rst_byte_nxt;
  logic [15:0] silence_r, silence_nxt;

  logic [3:0]  p;
  logic [7:0]  b;
  logic [3:0]  stick_off;
  logic [1:0]  stick_idx;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    own_addr_nxt = own_addr_r;
    timeout_nxt  = timeout_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_OWN_ADDR:     own_addr_nxt = cfg_ch.data;
        CFG_LINK_TIMEOUT: timeout_nxt  = cfg_ch.data[15:0];
        default:          ;
      endcase
    end
  end

  assign p         = cnt_r;
  assign b         = stage.beat.data_byte;
  assign stick_off = p - STICK_BASE;
  assign stick_idx = stick_off[2:1];

  always_comb begin
    cnt_nxt      = cnt_r;
    sum_nxt      = sum_r;
    first_nxt    = first_r;
    target_nxt   = target_r;
    stick_nxt    = stick_r;
    flag_nxt     = flag_r;
    rst_byte_nxt = rst_byte_r;
    silence_nxt  = silence_r;
    res_valid    = 1'b0;
    res          = '0;

    if (advance) begin
      if (stage.beat.operation == OP_TICK) begin
        if (silence_r != SILENCE_MAX) begin
          silence_nxt = silence_r + 16'd1;
        end
        res_valid     = 1'b1;
        res.status    = STATUS_LINK;
        res.link_up   = (silence_nxt < timeout_r);
      end else begin
        if (p == '0) begin
          first_nxt = b;
        end
        if (p <= ADDR_LAST) begin
          target_nxt[8*p[1:0] +: 8] = b;
        end else if (p <= STICK_LAST) begin
          if (!stick_off[0]) begin
            stick_nxt[stick_idx][7:0] = b;
          end else begin
            stick_nxt[stick_idx][15:8] = b;
          end
        end else if (p == FLAG_POS) begin
          flag_nxt = b;
        end else if (p == CHECK_POS) begin
          rst_byte_nxt = b;
        end

        if (!stage.beat.last_byte) begin
          if (p <= CHECK_POS) begin
            sum_nxt = sum_r + b;
          end
          if (p != COUNT_MAX) begin
            cnt_nxt = p + 4'd1;
          end
        end else begin
          cnt_nxt = '0;
          sum_nxt = '0;
          // A two-byte beacon is dropped without a result.
          if (p == 4'd1 && first_r == BEACON_FIRST && b == BEACON_SECOND) begin
            res_valid = 1'b0;
          end else if (p != LAST_POS) begin
            res_valid  = 1'b1;
            res.status = STATUS_LEN_ERR;
          end else begin
            silence_nxt       = '0;
            res_valid         = 1'b1;
            res.sender_target = target_r;
            if (target_r != own_addr_r) begin
              res.status = STATUS_ADDR_ERR;
            end else if (sum_r != b) begin
              res.status = STATUS_SUM_ERR;
            end else begin
              res.status         = STATUS_OK;
              res.throttle       = stick_scale(stick_r[0]);
              res.roll           = stick_scale(stick_r[1]);
              res.pitch          = stick_scale(stick_r[2]);
              res.yaw            = stick_scale(stick_r[3]);
              res.arm            = flag_r[FLAG_ARM];
              res.flip           = flag_r[FLAG_FLIP];
              res.rate_mode      = flag_r[FLAG_RATE];
              res.auto_altitude  = flag_r[FLAG_ALT];
              res.attitude_reset = rst_byte_r;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r <= '0;
      timeout_r  <= LINK_TIMEOUT_RST;
      cnt_r      <= '0;
      sum_r      <= '0;
      first_r    <= '0;
      target_r   <= '0;
      stick_r    <= '{default: '0};
      flag_r     <= '0;
      rst_byte_r <= '0;
      silence_r  <= '0;
    end else begin
      own_addr_r <= own_addr_nxt;
      timeout_r  <= timeout_nxt;
      cnt_r      <= cnt_nxt;
      sum_r      <= sum_nxt;
      first_r    <= first_nxt;
      target_r   <= target_nxt;
      stick_r    <= stick_nxt;
      flag_r     <= flag_nxt;
      rst_byte_r <= rst_byte_nxt;
      silence_r  <= silence_nxt;
    end
  end

  a_last_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    advance && stage.beat.operation == OP_BYTE && stage.beat.last_byte
    |=> cnt_r == '0 && sum_r == '0) else $error("packet end did not clear count");

  a_tick_keeps_packet: assert property (@(posedge clk) disable iff (!rst_n)
    advance && stage.beat.operation == OP_TICK |=> $stable(cnt_r) && $stable(sum_r))
    else $error("tick disturbed packet assembly");

  a_tick_counts: assert property (@(posedge clk) disable iff (!rst_n)
    advance && stage.beat.operation == OP_TICK |=> silence_r != '0)
    else $error("silence counter did not count");

  a_byte_no_link: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && stage.beat.operation == OP_BYTE |-> res.status != STATUS_LINK)
    else $error("packet byte gave a link report");

endmodule

// ===== rtl/core/rccp_out_stage.sv =====
// Result register that drives the result channel.
module rccp_out_stage import rccp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  result_t    res,
  output logic       free,
  rccp_out_if.source out_ch
);

  logic    valid_r, valid_nxt;
  result_t res_r, res_nxt;

  assign free = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (load) begin
      valid_nxt = 1'b1;
      res_nxt   = res;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.status         = res_r.status;
  assign out_ch.sender_target  = res_r.sender_target;
  assign out_ch.throttle       = res_r.throttle;
  assign out_ch.roll           = res_r.roll;
  assign out_ch.pitch          = res_r.pitch;
  assign out_ch.yaw            = res_r.yaw;
  assign out_ch.arm            = res_r.arm;
  assign out_ch.flip           = res_r.flip;
  assign out_ch.rate_mode      = res_r.rate_mode;
  assign out_ch.auto_altitude  = res_r.auto_altitude;
  assign out_ch.attitude_reset = res_r.attitude_reset;
  assign out_ch.link_up        = res_r.link_up;

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free) else $error("result overwritten before it was taken");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> valid_r) else $error("loaded result not presented");

  a_idle_empties: assert property (@(posedge clk) disable iff (!rst_n)
    !load && out_ch.ready |=> !valid_r) else $error("taken result presented twice");

endmodule

// ===== rtl/core/rc_control_packet_parser.sv =====
// Top level of the radio control packet parser.
//
//   channel  | dir | payload                                         | accepted when
//   in_ch    | in  | operation, data_byte, last_byte                 | valid && ready
//   out_ch   | out | status, sender_target, sticks, flags, link_up   | valid && ready
//   cfg_ch   | in  | index, data (own address, link timeout)         | valid && ready
//
// One beat per cycle sustained while out_ch does not stall; a beat's result enters
// the result register as the beat leaves the input register, via the packet logic.
// Reset (rst_n low, synchronous) empties both registers, clears the packet state and
// the silence counter, and restores own address 0 and link timeout 40.
// When out_ch stalls, the input register holds its beat and in_ch.ready drops only
// once both registers are full. Configuration writes are always taken.
module rc_control_packet_parser import rccp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  rccp_in_if.sink    in_ch,
  rccp_out_if.source out_ch,
  rccp_cfg_if.sink   cfg_ch
);

  stage_t  stage;
  logic    advance;
  logic    out_free;
  logic    res_valid;
  result_t res;

  // A beat leaves the input register only when the result register can take it.
  assign advance = stage.valid && out_free;

  rccp_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .advance (advance),
    .stage   (stage)
  );

  rccp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_ch    (cfg_ch),
    .stage     (stage),
    .advance   (advance),
    .res_valid (res_valid),
    .res       (res)
  );

  rccp_out_stage u_out_stage (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (res_valid),
    .res    (res),
    .free   (out_free),
    .out_ch (out_ch)
  );

endmodule
